// ===== design/fcfs_pkg.sv =====
// Shared types and constants for the frame clock with fixed-step accumulator.
// No dependencies; imported by frame_clock_fixed_step.
package fcfs_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_DELTA_CAP = 3'd0;
  localparam logic [2:0] REG_SCALE     = 3'd1;
  localparam logic [2:0] REG_STEP      = 3'd2;
  localparam logic [2:0] REG_STEP_CAP  = 3'd3;
  localparam logic [2:0] REG_TPS       = 3'd4;

  localparam logic [15:0] SCALE_RST = 16'd256;
  localparam logic [31:0] STEP_RST  = 32'd2457600;
  localparam logic [7:0]  MAXST_RST = 8'd5;
  localparam logic [31:0] TPS_RST   = 32'd147456000;

  localparam logic [39:0] MASK40    = {40{1'b1}};
  localparam logic [23:0] FPS_MAX   = {24{1'b1}};
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  // serial loop lengths, loaded as count minus one
  localparam logic [6:0] LEN_MULS = 7'd15;
  localparam logic [6:0] LEN_MULP = 7'd31;
  localparam logic [6:0] LEN_FDIV = 7'd71;
  localparam logic [6:0] LEN_CDIV = 7'd63;
  localparam logic [6:0] LEN_ADIV = 7'd15;

  localparam int TDATA_W = 296;

  typedef logic [63:0] u64_t;

endpackage

// ===== design/frame_clock_fixed_step.sv =====
// Frame clock: delta measure, clamp, scale, FPS window and fixed-step accumulator.
// Uses fcfs_pkg; one serial shift-add multiplier and one restoring divider.
//
// channel  dir  handshake           payload
// in_      in   tvalid/tready       tdata[63:0] timestamp
// out_     out  tvalid/tready       tdata (packed results), tuser fps_updated
// cfg_     in   valid/ready         index[2:0], data[31:0]
//
// One word runs from its accepting edge to out_tvalid through setup, the delta
// scale multiply and the scale state; when the FPS window closes, the frames*tps
// multiply and a 72-bit divide; then accumulate, the step count and alpha divides
// where the step settings call for them, and the output load. The next input word
// is taken once the result has loaded. Multiplies and divides run bit serially.
// rst_n is synchronous; it clears the state and restores register defaults.
// A result held by out_tready low does not block the next input word; the
// next result waits until the output register is free.
module frame_clock_fixed_step
  import fcfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // timestamp
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // clamped delta, scaled delta, step count, alpha, fps, frame number,
  // scaled sum, clamped sum, zero fill
  output logic [TDATA_W-1:0]   out_tdata,
  output logic                 out_tuser,  // fps_updated
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE  = 4'd1;
  localparam logic [3:0] S_MULS = 4'd2;
  localparam logic [3:0] S_SCL  = 4'd3;
  localparam logic [3:0] S_MULP = 4'd4;
  localparam logic [3:0] S_FDIV = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_CDIV = 4'd7;
  localparam logic [3:0] S_ADIV = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  state_r;
  logic [31:0] maxd_r;
  logic [15:0] scale_r;
  logic [31:0] step_r;
  logic [7:0]  maxst_r;
  logic [31:0] tps_r;

  u64_t        last_r, accum_r, wt_r, rtot_r, stot_r, raw_r;
  logic        started_r, strt_r, upd_r;
  logic [31:0] wf_r, frames_r;
  logic [23:0] fps_r;
  logic [39:0] real_r, scaled_r;
  logic [7:0]  count_r;
  logic [16:0] alpha_r;
  logic [6:0]  cnt_r;

  // serial multiplier
  u64_t        mc_r, macc_r, macc_nxt;
  logic [31:0] mp_r;
  // restoring divider
  u64_t        rem_r, dvs_r, rem_nxt;
  logic [71:0] dvd_r;
  logic [23:0] q_r, q_nxt;
  logic        ov8_r, ov24_r, ov8_nxt, ov24_nxt;
  logic [64:0] rem_sh;
  logic        ge;

  logic [TDATA_W-1:0] odata_r;
  logic               ouser_r, ovalid_r;

  logic [64:0] wsum;
  u64_t        rclamp;
  logic [39:0] real_c;
  u64_t        asum;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  assign macc_nxt = mp_r[0] ? macc_r + mc_r : macc_r;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[71]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_nxt  = ge ? 64'(rem_sh - {1'b0, dvs_r}) : rem_sh[63:0];
    q_nxt    = {q_r[22:0], ge};
    ov8_nxt  = ov8_r | q_r[7];
    ov24_nxt = ov24_r | q_r[23];
  end

  always_comb begin
    wsum   = {1'b0, wt_r} + {1'b0, raw_r};
    rclamp = (maxd_r != 32'd0 && raw_r > {32'd0, maxd_r}) ? {32'd0, maxd_r} : raw_r;
    real_c = strt_r ? ((|rclamp[63:40]) ? MASK40 : rclamp[39:0]) : 40'd0;
    asum   = accum_r + {24'd0, scaled_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxd_r  <= '0;
      scale_r <= SCALE_RST;
      step_r  <= STEP_RST;
      maxst_r <= MAXST_RST;
      tps_r   <= TPS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELTA_CAP: maxd_r  <= cfg_data;
        REG_SCALE:     scale_r <= cfg_data[15:0];
        REG_STEP:      step_r  <= cfg_data;
        REG_STEP_CAP:  maxst_r <= cfg_data[7:0];
        REG_TPS:       tps_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      last_r    <= '0;
      accum_r   <= '0;
      wt_r      <= '0;
      wf_r      <= '0;
      fps_r     <= '0;
      frames_r  <= '0;
      rtot_r    <= '0;
      stot_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (ovalid_r && out_tready && state_r != S_OUT) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_r     <= in_tdata - last_r;
            strt_r    <= started_r;
            started_r <= 1'b1;
            last_r    <= in_tdata;
            frames_r  <= frames_r + 32'd1;
            state_r   <= S_PRE;
          end
        end
        S_PRE: begin
          if (strt_r) begin
            wt_r <= wsum[64] ? {64{1'b1}} : wsum[63:0];
            wf_r <= wf_r + 32'd1;
          end
          real_r  <= real_c;
          mc_r    <= {24'd0, real_c};
          state_r <= S_MULS;
          cnt_r   <= LEN_MULS;
          macc_r  <= '0;
          mp_r    <= {16'd0, scale_r};
        end
        S_MULS: begin
          macc_r <= macc_nxt;
          mc_r   <= mc_r << 1;
          mp_r   <= mp_r >> 1;
          cnt_r  <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) state_r <= S_SCL;
        end
        S_SCL: begin
          // macc_r holds real * scale
          scaled_r <= (|macc_r[63:48]) ? MASK40 : macc_r[47:8];
          rtot_r   <= rtot_r + {24'd0, real_r};
          stot_r   <= stot_r + ((|macc_r[63:48]) ? {24'd0, MASK40} : {24'd0, macc_r[47:8]});
          upd_r    <= strt_r && (wt_r >= {32'd0, tps_r});
          dvs_r    <= wt_r;
          mc_r     <= {32'd0, wf_r};
          mp_r     <= tps_r;
          macc_r   <= '0;
          cnt_r    <= LEN_MULP;
          if (strt_r && (wt_r >= {32'd0, tps_r})) begin
            wt_r <= '0;
            wf_r <= '0;
            if (wt_r == 64'd0) begin
              fps_r   <= FPS_MAX;
              state_r <= S_ACC;
            end else begin
              state_r <= S_MULP;
            end
          end else begin
            state_r <= S_ACC;
          end
        end
        S_MULP: begin
          macc_r <= macc_nxt;
          mc_r   <= mc_r << 1;
          mp_r   <= mp_r >> 1;
          cnt_r  <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            dvd_r   <= {macc_nxt, 8'd0};
            rem_r   <= '0;
            q_r     <= '0;
            ov8_r   <= 1'b0;
            ov24_r  <= 1'b0;
            cnt_r   <= LEN_FDIV;
            state_r <= S_FDIV;
          end
        end
        S_FDIV: begin
          rem_r  <= rem_nxt;
          dvd_r  <= dvd_r << 1;
          q_r    <= q_nxt;
          ov8_r  <= ov8_nxt;
          ov24_r <= ov24_nxt;
          cnt_r  <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            fps_r   <= ov24_nxt ? FPS_MAX : q_nxt;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          dvs_r  <= {32'd0, step_r};
          q_r    <= '0;
          ov8_r  <= 1'b0;
          ov24_r <= 1'b0;
          count_r <= '0;
          if (step_r == 32'd0) begin
            alpha_r <= ALPHA_ONE;
            state_r <= S_OUT;
          end else if (maxst_r == 8'd0) begin
            if (accum_r >= {32'd0, step_r}) begin
              alpha_r <= ALPHA_ONE;
              state_r <= S_OUT;
            end else begin
              rem_r   <= accum_r;
              dvd_r   <= '0;
              cnt_r   <= LEN_ADIV;
              state_r <= S_ADIV;
            end
          end else begin
            rem_r   <= '0;
            dvd_r   <= {asum, 8'd0};
            cnt_r   <= LEN_CDIV;
            state_r <= S_CDIV;
          end
        end
        S_CDIV: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_r << 1;
          q_r   <= q_nxt;
          ov8_r <= ov8_nxt;
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            accum_r <= rem_nxt;
            if (ov8_nxt || q_nxt[7:0] > maxst_r) count_r <= maxst_r;
            else                                  count_r <= q_nxt[7:0];
            q_r     <= '0;
            dvd_r   <= '0;
            cnt_r   <= LEN_ADIV;
            state_r <= S_ADIV;
          end
        end
        S_ADIV: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_r << 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            alpha_r <= {1'b0, q_nxt[15:0]};
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_tready) begin
            odata_r  <= {7'd0, rtot_r, stot_r, frames_r, fps_r, alpha_r, count_r,
                         scaled_r, real_r};
            ouser_r  <= upd_r;
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in progress");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[104:88] <= ALPHA_ONE))
    else $error("alpha above one");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[87:80] <= maxst_r))
    else $error("step count above its per-frame cap");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for frame_clock_fixed_step: random timestamps with idle gaps and stalls,
// register writes between phases. Depends on fcfs_pkg and the design files.
module tb;
  import fcfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [39:0] clamp_dt;
    logic [39:0] scaled_delta;
    logic [7:0]  step_count;
    logic [16:0] alpha_q16;
    logic [23:0] fps_q8;
    logic        fps_updated;
    logic [31:0] frame_number;
    logic [63:0] scaled_elapsed;
    logic [63:0] clamp_sum;
  } frame_res_t;

  class frame_clock_sb;
    logic [31:0] delta_cap, tps, step;
    logic [15:0] scale;
    logic [7:0]  max_st;
    logic [63:0] last_ts, accum, win_ticks, real_sum, scaled_sum;
    logic [31:0] win_frames, frames;
    logic [23:0] fps;
    bit          started;
    frame_res_t  pending[$];
    int          mismatches, fps_updates, step_frames;

    function new();
      delta_cap = 0; scale = SCALE_RST; step = STEP_RST; max_st = MAXST_RST;
      tps = TPS_RST; last_ts = 0; accum = 0; win_ticks = 0; real_sum = 0;
      scaled_sum = 0; win_frames = 0; frames = 0; fps = 0; started = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_DELTA_CAP: delta_cap = v;
        REG_SCALE:     scale = v[15:0];
        REG_STEP:      step = v;
        REG_STEP_CAP:  max_st = v[7:0];
        REG_TPS:       tps = v;
        default: ;
      endcase
    endfunction

    function void note_tick(logic [63:0] ts);
      frame_res_t r;
      logic [63:0] raw, rd, cnt;
      logic [64:0] sum;
      logic [71:0] num, q;
      logic [79:0] prod;
      r.fps_updated = 0;
      rd = 0;
      if (started) begin
        raw = ts - last_ts;
        sum = {1'b0, win_ticks} + raw;
        win_ticks = sum[64] ? '1 : sum[63:0];
        win_frames++;
        if (win_ticks >= {32'd0, tps}) begin
          if (win_ticks == 0) fps = FPS_MAX;
          else begin
            num = {8'd0, 64'(win_frames * 64'(tps))} << 8;
            q = num / win_ticks;
            fps = (q > FPS_MAX) ? FPS_MAX : q[23:0];
          end
          win_ticks = 0;
          win_frames = 0;
          r.fps_updated = 1;
        end
        rd = raw;
        if (delta_cap != 0 && rd > delta_cap) rd = delta_cap;
        if (rd > MASK40) rd = MASK40;
      end
      started = 1;
      last_ts = ts;
      prod = rd * scale;
      prod = prod >> 8;
      r.clamp_dt = rd[39:0];
      r.scaled_delta = (prod > MASK40) ? MASK40 : prod[39:0];
      real_sum += rd;
      scaled_sum += r.scaled_delta;
      frames++;
      cnt = 0;
      if (step != 0 && max_st != 0) begin
        accum += r.scaled_delta;
        cnt = accum / step;
        if (cnt > max_st) cnt = max_st;
        accum = accum % step;
      end
      if (step == 0 || accum >= step) r.alpha_q16 = ALPHA_ONE;
      else r.alpha_q16 = 17'((accum << 16) / step);
      r.step_count = cnt[7:0];
      r.fps_q8 = fps;
      r.frame_number = frames;
      r.scaled_elapsed = scaled_sum;
      r.clamp_sum = real_sum;
      pending.push_back(r);
    endfunction

    function void check_frame(frame_res_t a);
      frame_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, none pending");
        return;
      end
      e = pending.pop_front();
      if (e.fps_updated) fps_updates++;
      if (e.step_count != 0) step_frames++;
      if (a != e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch frame %0d: exp rd=%h sd=%h st=%h al=%h fps=%h upd=%b sc=%h re=%h",
                   e.frame_number, e.clamp_dt, e.scaled_delta, e.step_count, e.alpha_q16,
                   e.fps_q8, e.fps_updated, e.scaled_elapsed, e.clamp_sum);
          $display("  got rd=%h sd=%h st=%h al=%h fps=%h upd=%b fn=%h sc=%h re=%h",
                   a.clamp_dt, a.scaled_delta, a.step_count, a.alpha_q16, a.fps_q8,
                   a.fps_updated, a.frame_number, a.scaled_elapsed, a.clamp_sum);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [63:0] in_tdata;
  logic [TDATA_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  frame_clock_fixed_step dut (.*);

  frame_clock_sb sb = new();
  int cycles;
  bit no_idle, hold_off;
  logic [63:0] stamp;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("timeout, %0d words pending", sb.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    frame_res_t r;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        r.clamp_dt = out_tdata[39:0];
        r.scaled_delta = out_tdata[79:40];
        r.step_count = out_tdata[87:80];
        r.alpha_q16 = out_tdata[104:88];
        r.fps_q8 = out_tdata[128:105];
        r.frame_number = out_tdata[160:129];
        r.scaled_elapsed = out_tdata[224:161];
        r.clamp_sum = out_tdata[288:225];
        r.fps_updated = out_tuser;
        sb.check_frame(r);
      end
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else out_tready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  initial begin
    hold_off = 1;
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 0;
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_tick(logic [63:0] ts);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 22) @(negedge clk);
    in_tvalid <= 1; in_tdata <= ts;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(ts);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly display-like deltas, sometimes huge or backward jumps
  function automatic logic [63:0] next_delta();
    case ($urandom_range(9))
      0: return rand64();
      1: return 64'($urandom_range(3));
      2: return 64'($urandom) << $urandom_range(40);
      default: return 64'($urandom_range(1_000_000, 6_000_000));
    endcase
  endfunction

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) begin
      stamp += next_delta();
      send_tick(stamp);
    end
  endtask

  initial begin
    in_tvalid = 0; in_tdata = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    rst_n = 0; cycles = 0; no_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: first tick, zero delta, extremes, wrap of the timestamp;
    // the output holds off meanwhile, so the block fills and stalls its input
    send_tick(64'hFFFF_FFFF_FFFF_FFF0);
    send_tick(64'hFFFF_FFFF_FFFF_FFF0);
    send_tick(64'h0000_0000_0000_0010);
    send_tick(64'h0);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(64'h5555_5555_5555_5555);
    send_tick(64'hAAAA_AAAA_AAAA_AAAA);
    stamp = 64'hAAAA_AAAA_AAAA_AAAA;
    run_phase(8);
    drain();

    write_cfg(REG_DELTA_CAP, 32'hFFFF_FFFF);
    write_cfg(REG_SCALE, 32'h0000_FFFF);
    write_cfg(REG_STEP, 32'd1);
    write_cfg(REG_STEP_CAP, 32'hFF);
    write_cfg(REG_TPS, 32'd1);
    send_tick(stamp + 64'h1_0000_0000);
    send_tick(stamp + 64'h2_0000_0005);
    stamp = stamp + 64'h2_0000_0005;
    run_phase(6);
    drain();

    // zero step, zero max steps, zero tps, zero scale
    write_cfg(REG_STEP, 32'd0);
    write_cfg(REG_TPS, 32'd0);
    write_cfg(REG_SCALE, 32'd0);
    write_cfg(REG_DELTA_CAP, 32'd0);
    send_tick(stamp);
    run_phase(4);
    drain();
    write_cfg(REG_STEP, 32'd1000);
    write_cfg(REG_STEP_CAP, 32'd0);
    write_cfg(REG_SCALE, 32'd256);
    run_phase(4);
    drain();
    // lower step below the accumulator
    write_cfg(REG_STEP_CAP, 32'd5);
    write_cfg(REG_STEP, 32'd4_000_000);
    send_tick(stamp + 64'd3_900_000);
    stamp += 64'd3_900_000;
    drain();
    write_cfg(REG_STEP, 32'd100);
    write_cfg(REG_STEP_CAP, 32'd0);
    send_tick(stamp + 64'd10);
    stamp += 64'd10;
    drain();

    // random phases with varied registers; phase 3 runs with no idling
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(REG_DELTA_CAP, ($urandom_range(2) == 0) ? 32'd0 : $urandom);
      write_cfg(REG_SCALE, ($urandom_range(3) == 0) ? {16'd0, 16'($urandom)}
                                                    : $urandom_range(512));
      write_cfg(REG_STEP, ($urandom_range(4) == 0) ? $urandom : $urandom_range(3_000_000));
      write_cfg(REG_STEP_CAP, {24'd0, 8'($urandom)});
      write_cfg(REG_TPS, ($urandom_range(4) == 0) ? $urandom : $urandom_range(30_000_000));
      no_idle = (ph == 3);
      run_phase(100);
      drain();
    end
    no_idle = 0;
    drain();

    $display("ran %0d frames over several register settings; %0d fps updates, %0d stepping",
             sb.frames, sb.fps_updates, sb.step_frames);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
